### rtl/hall_tachometer_with_glitch_reject_assert.svh
// Assertion macros used by the tachometer controller.
`ifndef HALL_TACHOMETER_WITH_GLITCH_REJECT_ASSERT_SVH
`define HALL_TACHOMETER_WITH_GLITCH_REJECT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HTACH_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define HTACH_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/htach_pkg.sv
// Package: shared types and constants of the hall tachometer.
`timescale 1ns / 1ps
package htach_pkg;

   localparam int TS_W      = 32;
   localparam int STALL_W   = 32;
   localparam int PPR_W     = 8;
   localparam int SCALE_W   = 40;
   localparam int RATIO_W   = 4;
   localparam int RPM_W     = 16;
   localparam int ANGLE_W   = 9;
   localparam int STATUS_W  = 3;
   localparam int PERIOD_W  = 32;
   localparam int OP_W      = 2;

   localparam int ADDR_W    = 6;
   localparam int DATA_W    = 64;
   localparam int REG_IDX_W = 3;

   localparam int DIV_W     = 40;
   localparam int DSR_W     = 32;
   localparam int STEP_W    = 6;

   localparam int MOD_STEPS  = 9;
   localparam int ANG_STEPS  = 17;
   localparam int RPM_STEPS  = 40;
   localparam int GEAR_STEPS = 16;

   localparam int DEGREES     = 360;
   localparam int GLITCH_NUM  = 6;
   localparam int GLITCH_DEN  = 10;
   localparam logic [RPM_W-1:0] RPM_MAX = 16'hFFFF;
   localparam logic [PERIOD_W-1:0] NO_PERIOD = 32'hFFFF_FFFF;

   localparam logic [STALL_W-1:0] STALL_LIMIT_RST = 32'd80000000;
   localparam logic [PPR_W-1:0]   HALL_PPR_RST    = 8'd12;
   localparam logic [PPR_W-1:0]   GEAR_PPR_RST    = 8'd54;
   localparam logic [SCALE_W-1:0] RPM_SCALE_RST   = 40'd4800000000;
   localparam logic [RATIO_W-1:0] GEAR_RATIO_RST  = 4'd6;

   localparam logic [REG_IDX_W-1:0] REG_STALL_LIMIT = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_HALL_PPR    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_GEAR_PPR    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_RPM_SCALE   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_GEAR_RATIO  = 3'd4;

   localparam logic [STATUS_W-1:0] ST_PRIMED      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_GLITCH      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EDGE_STALL  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_PULSE       = 3'd3;
   localparam logic [STATUS_W-1:0] ST_REVOLUTION  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_CHECK_IDLE  = 3'd5;
   localparam logic [STATUS_W-1:0] ST_CHECK_OK    = 3'd6;
   localparam logic [STATUS_W-1:0] ST_CHECK_STALL = 3'd7;

   localparam logic CMD_EDGE  = 1'b0;
   localparam logic CMD_CHECK = 1'b1;

   localparam logic [OP_W-1:0] OP_MOD  = 2'd0;
   localparam logic [OP_W-1:0] OP_ANG  = 2'd1;
   localparam logic [OP_W-1:0] OP_RPM  = 2'd2;
   localparam logic [OP_W-1:0] OP_GEAR = 2'd3;

   typedef struct packed {
      logic [STALL_W-1:0] stall_limit;
      logic [PPR_W-1:0]   hall_pulses_per_rev;
      logic [PPR_W-1:0]   gear_pulses_per_rev;
      logic [SCALE_W-1:0] rpm_scale;
      logic [RATIO_W-1:0] gear_ratio;
   } htach_cfg_type;

   typedef struct packed {
      logic            load_item;
      logic            eval;
      logic            div_start;
      logic [OP_W-1:0] div_op;
      logic            out_load;
   } htach_cmd_type;

   typedef struct packed {
      logic good_edge;
      logic rev;
      logic div_busy;
      logic div_done;
      logic slot_free;
   } htach_sts_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [RPM_W-1:0]    motor_rpm;
      logic [RPM_W-1:0]    gear_rpm;
      logic [PPR_W-1:0]    gear_pulse_index;
      logic [ANGLE_W-1:0]  gear_angle;
      logic [PERIOD_W-1:0] revolution_period;
   } htach_rsp_type;

endpackage

### rtl/htach_if.sv
// Interfaces: input word channel and result word channel.
`timescale 1ns / 1ps
interface htach_req_if import htach_pkg::*;;
   logic            valid;
   logic            ready;
   logic            command;
   logic [TS_W-1:0] timestamp;

   modport source (output valid, command, timestamp, input ready);
   modport sink (input valid, command, timestamp, output ready);
endinterface

interface htach_rsp_if import htach_pkg::*;;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [RPM_W-1:0]    motor_rpm;
   logic [RPM_W-1:0]    gear_rpm;
   logic [PPR_W-1:0]    gear_pulse_index;
   logic [ANGLE_W-1:0]  gear_angle;
   logic [PERIOD_W-1:0] revolution_period;

   modport source (output valid, status, motor_rpm, gear_rpm, gear_pulse_index, gear_angle,
                   revolution_period, input ready);
   modport sink (input valid, status, motor_rpm, gear_rpm, gear_pulse_index, gear_angle,
                 revolution_period, output ready);
endinterface

### rtl/htach_csr.sv
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps
module htach_csr import htach_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output htach_cfg_type     cfg
);

   htach_cfg_type        cfg_ff, cfg_in;
   logic                 wr_en;
   logic [REG_IDX_W-1:0] idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;
   assign idx    = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_STALL_LIMIT: cfg_in.stall_limit         = pwdata[STALL_W-1:0];
            REG_HALL_PPR:    cfg_in.hall_pulses_per_rev = pwdata[PPR_W-1:0];
            REG_GEAR_PPR:    cfg_in.gear_pulses_per_rev = pwdata[PPR_W-1:0];
            REG_RPM_SCALE:   cfg_in.rpm_scale           = pwdata[SCALE_W-1:0];
            REG_GEAR_RATIO:  cfg_in.gear_ratio          = pwdata[RATIO_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_STALL_LIMIT: prdata = DATA_W'(cfg_ff.stall_limit);
         REG_HALL_PPR:    prdata = DATA_W'(cfg_ff.hall_pulses_per_rev);
         REG_GEAR_PPR:    prdata = DATA_W'(cfg_ff.gear_pulses_per_rev);
         REG_RPM_SCALE:   prdata = DATA_W'(cfg_ff.rpm_scale);
         REG_GEAR_RATIO:  prdata = DATA_W'(cfg_ff.gear_ratio);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stall_limit         <= STALL_LIMIT_RST;
         cfg_ff.hall_pulses_per_rev <= HALL_PPR_RST;
         cfg_ff.gear_pulses_per_rev <= GEAR_PPR_RST;
         cfg_ff.rpm_scale           <= RPM_SCALE_RST;
         cfg_ff.gear_ratio          <= GEAR_RATIO_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/htach_div.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions.
`timescale 1ns / 1ps
module htach_div import htach_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [DSR_W-1:0]  divisor,
   input  logic [STEP_W-1:0] steps,
   output logic              busy,
   output logic              done,
   output logic [DIV_W-1:0]  quotient,
   output logic [DSR_W-1:0]  remainder
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]  dvd_ff, dvd_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DSR_W-1:0]  rem_ff, rem_in;
   logic [DSR_W-1:0]  dsr_ff, dsr_in;
   logic [DSR_W:0]    trial;
   logic              fits;

   assign trial = {rem_ff, dvd_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = steps;
         dvd_in  = dividend;
         quo_in  = '0;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DIV_W-2:0], 1'b0};
         quo_in = {quo_ff[DIV_W-2:0], fits};
         rem_in = fits ? DSR_W'(trial - {1'b0, dsr_ff}) : trial[DSR_W-1:0];
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

### rtl/htach_dp.sv
// Datapath: tachometer state, period checks, divider operands and result register.
`timescale 1ns / 1ps
module htach_dp import htach_pkg::*; #(
   parameter int TIMESTAMP_BITS = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  htach_cfg_type   cfg,
   input  htach_cmd_type   cmd,
   output htach_sts_type   sts,
   input  logic            req_command,
   input  logic [TS_W-1:0] req_timestamp,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output htach_rsp_type   rsp_word
);

   localparam int TB = TIMESTAMP_BITS;
   localparam int NW = (TB < TS_W) ? TB : TS_W;
   localparam int DW = (TB > STALL_W) ? TB : STALL_W;
   localparam int GW = DW + 4;

   logic                cmd_ff;
   logic [TB-1:0]       now_ff;
   logic [TB-1:0]       prev_ff, prev_in;
   logic                primed_ff, primed_in;
   logic [PERIOD_W-1:0] lg_ff, lg_in;
   logic                lgv_ff, lgv_in;
   logic [PERIOD_W-1:0] sum_ff, sum_in;
   logic [PPR_W-1:0]    pc_ff, pc_in;
   logic [PPR_W-1:0]    gc_ff, gc_in;
   logic [RPM_W-1:0]    rpm_ff, rpm_in;
   logic [RPM_W-1:0]    grpm_ff, grpm_in;
   logic [ANGLE_W-1:0]  angle_ff, angle_in;
   logic [PERIOD_W-1:0] revp_ff, revp_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                rev_ff, rev_in;
   logic [OP_W-1:0]     op_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   htach_rsp_type       out_ff;

   logic [TB-1:0]       delta;
   logic [DW-1:0]       delta_w;
   logic                over_limit;
   logic                glitch;
   logic [PERIOD_W:0]   sum_wide;
   logic [PERIOD_W-1:0] sum_next;
   logic [PPR_W-1:0]    pc_inc;
   logic [PPR_W-1:0]    hppr_eff;
   logic [PPR_W-1:0]    gppr_eff;
   logic [RATIO_W-1:0]  ratio_eff;
   logic                good_edge;
   logic [ANG_STEPS-1:0] ang_prod;

   logic [DIV_W-1:0]    div_dividend;
   logic [DSR_W-1:0]    div_divisor;
   logic [STEP_W-1:0]   div_steps;
   logic                div_busy, div_done;
   logic [DIV_W-1:0]    div_quo;
   logic [DSR_W-1:0]    div_rem;

   assign delta      = prev_ff - now_ff;
   assign delta_w    = DW'(delta);
   assign over_limit = delta_w > DW'(cfg.stall_limit);
   // delta < floor(6 * last / 10)  <=>  10 * delta + 10 <= 6 * last
   assign glitch     = lgv_ff && ((GW'(delta_w) * GW'(GLITCH_DEN) + GW'(GLITCH_DEN))
                                  <= (GW'(lg_ff) * GW'(GLITCH_NUM)));
   assign sum_wide   = {1'b0, sum_ff} + {1'b0, delta_w[PERIOD_W-1:0]};
   assign sum_next   = sum_wide[PERIOD_W] ? NO_PERIOD : sum_wide[PERIOD_W-1:0];
   assign pc_inc     = pc_ff + PPR_W'(1);
   assign hppr_eff   = (cfg.hall_pulses_per_rev == '0) ? PPR_W'(1) : cfg.hall_pulses_per_rev;
   assign gppr_eff   = (cfg.gear_pulses_per_rev == '0) ? PPR_W'(1) : cfg.gear_pulses_per_rev;
   assign ratio_eff  = (cfg.gear_ratio == '0) ? RATIO_W'(1) : cfg.gear_ratio;
   assign good_edge  = (cmd_ff == CMD_EDGE) && primed_ff && !glitch && !over_limit;
   assign ang_prod   = ANG_STEPS'(gc_ff) * ANG_STEPS'(DEGREES);

   always_comb begin
      case (cmd.div_op)
         OP_MOD: begin
            div_dividend = {MOD_STEPS'(gc_ff) + MOD_STEPS'(1), (DIV_W - MOD_STEPS)'(0)};
            div_divisor  = DSR_W'(gppr_eff);
            div_steps    = STEP_W'(MOD_STEPS);
         end
         OP_ANG: begin
            div_dividend = {ang_prod, (DIV_W - ANG_STEPS)'(0)};
            div_divisor  = DSR_W'(gppr_eff);
            div_steps    = STEP_W'(ANG_STEPS);
         end
         OP_RPM: begin
            div_dividend = DIV_W'(cfg.rpm_scale);
            div_divisor  = sum_ff;
            div_steps    = STEP_W'(RPM_STEPS);
         end
         default: begin
            div_dividend = {rpm_ff, (DIV_W - GEAR_STEPS)'(0)};
            div_divisor  = DSR_W'(ratio_eff);
            div_steps    = STEP_W'(GEAR_STEPS);
         end
      endcase
   end

   htach_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .steps     (div_steps),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      prev_in   = prev_ff;
      primed_in = primed_ff;
      lg_in     = lg_ff;
      lgv_in    = lgv_ff;
      sum_in    = sum_ff;
      pc_in     = pc_ff;
      gc_in     = gc_ff;
      rpm_in    = rpm_ff;
      grpm_in   = grpm_ff;
      angle_in  = angle_ff;
      revp_in   = revp_ff;
      status_in = status_ff;
      rev_in    = rev_ff;
      if (cmd.eval) begin
         if (cmd_ff == CMD_EDGE) begin
            if (!primed_ff) begin
               prev_in   = now_ff;
               primed_in = 1'b1;
               status_in = ST_PRIMED;
            end else if (glitch) begin
               status_in = ST_GLITCH;
            end else if (over_limit) begin
               prev_in   = now_ff;
               rpm_in    = '0;
               sum_in    = '0;
               pc_in     = '0;
               lg_in     = NO_PERIOD;
               lgv_in    = 1'b0;
               status_in = ST_EDGE_STALL;
            end else begin
               prev_in   = now_ff;
               lg_in     = delta_w[PERIOD_W-1:0];
               lgv_in    = 1'b1;
               sum_in    = sum_next;
               pc_in     = pc_inc;
               rev_in    = pc_inc >= hppr_eff;
               status_in = (pc_inc >= hppr_eff) ? ST_REVOLUTION : ST_PULSE;
            end
         end else begin
            if (!primed_ff) begin
               status_in = ST_CHECK_IDLE;
            end else if (over_limit) begin
               rpm_in    = '0;
               grpm_in   = '0;
               revp_in   = '0;
               primed_in = 1'b0;
               sum_in    = '0;
               pc_in     = '0;
               status_in = ST_CHECK_STALL;
            end else begin
               status_in = ST_CHECK_OK;
            end
         end
      end else if (div_done) begin
         case (op_ff)
            OP_MOD: gc_in = div_rem[PPR_W-1:0];
            OP_ANG: angle_in = div_quo[ANGLE_W-1:0];
            OP_RPM: begin
               rpm_in  = (div_quo > DIV_W'(RPM_MAX)) ? RPM_MAX : div_quo[RPM_W-1:0];
               revp_in = sum_ff;
            end
            default: begin
               grpm_in = div_quo[RPM_W-1:0];
               sum_in  = '0;
               pc_in   = '0;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         primed_ff    <= 1'b0;
         lg_ff        <= NO_PERIOD;
         lgv_ff       <= 1'b0;
         sum_ff       <= '0;
         pc_ff        <= '0;
         gc_ff        <= '0;
         rpm_ff       <= '0;
         grpm_ff      <= '0;
         angle_ff     <= '0;
         revp_ff      <= '0;
         rev_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prev_ff      <= prev_in;
         primed_ff    <= primed_in;
         lg_ff        <= lg_in;
         lgv_ff       <= lgv_in;
         sum_ff       <= sum_in;
         pc_ff        <= pc_in;
         gc_ff        <= gc_in;
         rpm_ff       <= rpm_in;
         grpm_ff      <= grpm_in;
         angle_ff     <= angle_in;
         revp_ff      <= revp_in;
         rev_ff       <= rev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      if (cmd.load_item) begin
         cmd_ff <= req_command;
         now_ff <= TB'(req_timestamp[NW-1:0]);
      end
      if (cmd.div_start) begin
         op_ff <= cmd.div_op;
      end
      if (cmd.out_load) begin
         out_ff.status            <= status_ff;
         out_ff.motor_rpm         <= rpm_ff;
         out_ff.gear_rpm          <= grpm_ff;
         out_ff.gear_pulse_index  <= gc_ff;
         out_ff.gear_angle        <= angle_ff;
         out_ff.revolution_period <= revp_ff;
      end
   end

   assign sts.good_edge = good_edge;
   assign sts.rev       = rev_ff;
   assign sts.div_busy  = div_busy;
   assign sts.div_done  = div_done;
   assign sts.slot_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = out_ff;

endmodule

### rtl/htach_ctrl.sv
// Controller: sequences evaluation, divisions and the result word.
`timescale 1ns / 1ps
`include "hall_tachometer_with_glitch_reject_assert.svh"
module htach_ctrl import htach_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  htach_sts_type sts,
   output htach_cmd_type cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_EVAL   = 4'd1;
   localparam logic [3:0] S_MOD    = 4'd2;
   localparam logic [3:0] S_MOD_W  = 4'd3;
   localparam logic [3:0] S_ANG    = 4'd4;
   localparam logic [3:0] S_ANG_W  = 4'd5;
   localparam logic [3:0] S_RPM    = 4'd6;
   localparam logic [3:0] S_RPM_W  = 4'd7;
   localparam logic [3:0] S_GEAR   = 4'd8;
   localparam logic [3:0] S_GEAR_W = 4'd9;
   localparam logic [3:0] S_OUT    = 4'd10;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd.load_item = 1'b0;
      cmd.eval      = 1'b0;
      cmd.div_start = 1'b0;
      cmd.div_op    = OP_MOD;
      cmd.out_load  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = sts.good_edge ? S_MOD : S_OUT;
         end
         S_MOD: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = OP_MOD;
            state_in      = S_MOD_W;
         end
         S_MOD_W: begin
            if (sts.div_done) begin
               state_in = S_ANG;
            end
         end
         S_ANG: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = OP_ANG;
            state_in      = S_ANG_W;
         end
         S_ANG_W: begin
            if (sts.div_done) begin
               state_in = sts.rev ? S_RPM : S_OUT;
            end
         end
         S_RPM: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = OP_RPM;
            state_in      = S_RPM_W;
         end
         S_RPM_W: begin
            if (sts.div_done) begin
               state_in = S_GEAR;
            end
         end
         S_GEAR: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = OP_GEAR;
            state_in      = S_GEAR_W;
         end
         S_GEAR_W: begin
            if (sts.div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (sts.slot_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `HTACH_ASSERT_IMP(a_div_start_idle, clock, reset, cmd.div_start, !sts.div_busy, "divider started while busy")
   `HTACH_ASSERT_IMP(a_out_slot_free, clock, reset, cmd.out_load, sts.slot_free, "result word overwritten")
   `HTACH_ASSERT_NXT(a_accept_eval, clock, reset, req_valid && req_ready, state_ff == S_EVAL, "accepted word not evaluated")

endmodule

### rtl/hall_tachometer_with_glitch_reject.sv
// Top level: hall sensor period tachometer with glitch rejection.
//
//   port         dir     width  purpose
//   req_chan     sink    1+32   command and down-counter timestamp word
//   rsp_chan     source  3+...  status, RPMs, gear index, angle, revolution period
//   psel..pready apb     6/64   configuration registers at 8*index
//
// Check, priming, glitch and stall words skip the divider. An accepted pulse
// runs the gear index and angle divisions; a revolution adds the RPM and gear
// RPM ones, on the shared restoring divider, one quotient bit per cycle.
// One word is in work at a time; a new word is taken while the result waits.
// Reset is synchronous; a stalled result holds while the next word is worked.
`timescale 1ns / 1ps
module hall_tachometer_with_glitch_reject import htach_pkg::*; #(
   parameter int TIMESTAMP_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   htach_req_if.sink         req_chan,
   htach_rsp_if.source       rsp_chan,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   htach_cfg_type cfg;
   htach_cmd_type cmd;
   htach_sts_type sts;
   htach_rsp_type rsp_word;
   logic          req_ready;
   logic          rsp_valid;

   htach_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   htach_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   htach_dp #(
      .TIMESTAMP_BITS (TIMESTAMP_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .cmd           (cmd),
      .sts           (sts),
      .req_command   (req_chan.command),
      .req_timestamp (req_chan.timestamp),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_word      (rsp_word)
   );

   assign req_chan.ready             = req_ready;
   assign rsp_chan.valid             = rsp_valid;
   assign rsp_chan.status            = rsp_word.status;
   assign rsp_chan.motor_rpm         = rsp_word.motor_rpm;
   assign rsp_chan.gear_rpm          = rsp_word.gear_rpm;
   assign rsp_chan.gear_pulse_index  = rsp_word.gear_pulse_index;
   assign rsp_chan.gear_angle        = rsp_word.gear_angle;
   assign rsp_chan.revolution_period = rsp_word.revolution_period;

endmodule

### sim/testbench.sv
// Testbench for the hall tachometer: directed and random words checked against a predictor.
`timescale 1ns / 1ps
module testbench;
   import htach_pkg::*;

   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int HOLD_CYCLES = 600;
   localparam int SETTLE_CYCLES = 100;

   logic clock = 1'b0;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic pready;

   htach_req_if req_chan ();
   htach_rsp_if rsp_chan ();

   hall_tachometer_with_glitch_reject DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor copy of configuration and tachometer state
   htach_cfg_type       tach_cfg;
   logic [TS_W-1:0]     last_edge_time;
   logic                is_primed;
   logic [PERIOD_W-1:0] last_period;
   logic                last_period_valid;
   logic [PERIOD_W-1:0] running_sum;
   logic [PPR_W-1:0]    hall_count;
   logic [PPR_W-1:0]    gear_index;
   logic [RPM_W-1:0]    motor_rpm_q;
   logic [RPM_W-1:0]    gear_rpm_q;
   logic [ANGLE_W-1:0]  angle_q;
   logic [PERIOD_W-1:0] rev_period_q;

   htach_rsp_type pending_readings[$];
   htach_rsp_type want_reading;
   htach_rsp_type got_reading;
   int            mismatches = 0;
   int            cycle_count = 0;

   logic [TS_W-1:0] timer_now;
   int sender_burst_left = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int rx_mode = 0;
   int rx_mode_left = 0;

   function automatic htach_rsp_type predict_reading(logic cmd, logic [TS_W-1:0] ts);
      logic [TS_W-1:0]     gap32;
      logic [63:0]         delta;
      logic [63:0]         sum;
      logic [63:0]         rpm;
      logic [63:0]         gpr;
      logic [63:0]         hppr;
      logic [63:0]         ratio;
      logic [63:0]         gidx;
      logic [63:0]         tmp;
      logic [STATUS_W-1:0] st;
      htach_rsp_type       r;
      gpr   = (tach_cfg.gear_pulses_per_rev == 0) ? 64'd1 : {56'b0, tach_cfg.gear_pulses_per_rev};
      hppr  = (tach_cfg.hall_pulses_per_rev == 0) ? 64'd1 : {56'b0, tach_cfg.hall_pulses_per_rev};
      ratio = (tach_cfg.gear_ratio == 0) ? 64'd1 : {60'b0, tach_cfg.gear_ratio};
      gap32 = last_edge_time - ts;
      delta = {32'b0, gap32};
      if (cmd == CMD_EDGE) begin
         if (!is_primed) begin
            last_edge_time = ts;
            is_primed = 1'b1;
            st = ST_PRIMED;
         end else if (last_period_valid &&
                      delta < ({32'b0, last_period} * GLITCH_NUM) / GLITCH_DEN) begin
            st = ST_GLITCH;
         end else begin
            last_edge_time = ts;
            if (delta > {32'b0, tach_cfg.stall_limit}) begin
               motor_rpm_q = '0;
               running_sum = '0;
               hall_count = '0;
               last_period = NO_PERIOD;
               last_period_valid = 1'b0;
               st = ST_EDGE_STALL;
            end else begin
               last_period = gap32;
               last_period_valid = 1'b1;
               gidx = ({56'b0, gear_index} + 64'd1) % gpr;
               gear_index = gidx[PPR_W-1:0];
               tmp = (gidx * DEGREES) / gpr;
               angle_q = tmp[ANGLE_W-1:0];
               sum = {32'b0, running_sum} + delta;
               running_sum = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
               hall_count = hall_count + 8'd1;
               if ({56'b0, hall_count} >= hppr) begin
                  rev_period_q = running_sum;
                  if (running_sum == 0) begin
                     rpm = {48'b0, RPM_MAX};
                  end else begin
                     rpm = {24'b0, tach_cfg.rpm_scale} / {32'b0, running_sum};
                     if (rpm > {48'b0, RPM_MAX}) rpm = {48'b0, RPM_MAX};
                  end
                  motor_rpm_q = rpm[RPM_W-1:0];
                  tmp = rpm / ratio;
                  gear_rpm_q = tmp[RPM_W-1:0];
                  running_sum = '0;
                  hall_count = '0;
                  st = ST_REVOLUTION;
               end else begin
                  st = ST_PULSE;
               end
            end
         end
      end else if (!is_primed) begin
         st = ST_CHECK_IDLE;
      end else if (delta > {32'b0, tach_cfg.stall_limit}) begin
         motor_rpm_q = '0;
         gear_rpm_q = '0;
         rev_period_q = '0;
         is_primed = 1'b0;
         running_sum = '0;
         hall_count = '0;
         st = ST_CHECK_STALL;
      end else begin
         st = ST_CHECK_OK;
      end
      r.status = st;
      r.motor_rpm = motor_rpm_q;
      r.gear_rpm = gear_rpm_q;
      r.gear_pulse_index = gear_index;
      r.gear_angle = angle_q;
      r.revolution_period = rev_period_q;
      return r;
   endfunction

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Result checker
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got_reading.status = rsp_chan.status;
         got_reading.motor_rpm = rsp_chan.motor_rpm;
         got_reading.gear_rpm = rsp_chan.gear_rpm;
         got_reading.gear_pulse_index = rsp_chan.gear_pulse_index;
         got_reading.gear_angle = rsp_chan.gear_angle;
         got_reading.revolution_period = rsp_chan.revolution_period;
         if (pending_readings.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual status %0d",
                     $time, got_reading.status);
            mismatches++;
         end else begin
            want_reading = pending_readings.pop_front();
            compare_field("status", want_reading.status, got_reading.status);
            compare_field("motor_rpm", want_reading.motor_rpm, got_reading.motor_rpm);
            compare_field("gear_rpm", want_reading.gear_rpm, got_reading.gear_rpm);
            compare_field("gear_pulse_index", want_reading.gear_pulse_index,
                          got_reading.gear_pulse_index);
            compare_field("gear_angle", want_reading.gear_angle, got_reading.gear_angle);
            compare_field("revolution_period", want_reading.revolution_period,
                          got_reading.revolution_period);
         end
      end
   end

   // Receiver stall pattern, with long hold-offs on request
   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served++;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(5, 60);
         end
         rx_mode_left--;
         case (rx_mode)
            0: rsp_chan.ready <= 1'b1;
            1: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   task automatic send_word(logic cmd, logic [TS_W-1:0] ts);
      int gap;
      if (sender_burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         sender_burst_left = $urandom_range(1, 20);
         if (gap > 0) begin
            @(negedge clock);
            req_chan.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_chan.valid <= 1'b1;
      req_chan.command <= cmd;
      req_chan.timestamp <= ts;
      do @(posedge clock); while (!req_chan.ready);
      pending_readings.push_back(predict_reading(cmd, ts));
      sender_burst_left--;
   endtask

   task automatic send_edge_after(logic [TS_W-1:0] period);
      timer_now = timer_now - period;
      send_word(CMD_EDGE, timer_now);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      sender_burst_left = 0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 3'b000};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      case (idx)
         REG_STALL_LIMIT: tach_cfg.stall_limit = value[STALL_W-1:0];
         REG_HALL_PPR:    tach_cfg.hall_pulses_per_rev = value[PPR_W-1:0];
         REG_GEAR_PPR:    tach_cfg.gear_pulses_per_rev = value[PPR_W-1:0];
         REG_RPM_SCALE:   tach_cfg.rpm_scale = value[SCALE_W-1:0];
         REG_GEAR_RATIO:  tach_cfg.gear_ratio = value[RATIO_W-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [STALL_W-1:0] stall, logic [PPR_W-1:0] hppr,
                            logic [PPR_W-1:0] gppr, logic [SCALE_W-1:0] scale,
                            logic [RATIO_W-1:0] ratio);
      wait_idle();
      write_register(REG_STALL_LIMIT, {32'b0, stall});
      write_register(REG_HALL_PPR, {56'b0, hppr});
      write_register(REG_GEAR_PPR, {56'b0, gppr});
      write_register(REG_RPM_SCALE, {24'b0, scale});
      write_register(REG_GEAR_RATIO, {60'b0, ratio});
   endtask

   // Mostly well-formed edge trains around a base period, with glitches, stalls and noise
   task automatic run_random_phase(int count, logic [31:0] base);
      int          kind;
      logic [63:0] period;
      logic [TS_W-1:0] ts;
      logic        cmd;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            period = {32'b0, base} - base / 5 + $urandom_range(0, (base / 5) * 2);
            send_edge_after(period[31:0]);
         end else if (kind < 78) begin
            period = $urandom_range(0, base / 2);
            send_word(CMD_EDGE, timer_now - period[31:0]);
         end else if (kind < 83) begin
            period = {32'b0, tach_cfg.stall_limit} + 64'd1 + $urandom_range(0, base);
            send_edge_after(period[31:0]);
         end else if (kind < 93) begin
            send_word(CMD_CHECK, timer_now - $urandom_range(0, base));
         end else if (kind < 97) begin
            send_word(CMD_CHECK,
                      timer_now - tach_cfg.stall_limit - 32'd1 - $urandom_range(0, 1000));
         end else begin
            ts = $urandom;
            cmd = $urandom_range(0, 1);
            if (cmd == CMD_EDGE) timer_now = ts;
            send_word(cmd, ts);
         end
      end
   endtask

   task automatic test_reset_defaults();
      timer_now = 32'hFFFF_FFFF;
      send_word(CMD_CHECK, 32'h0);
      send_word(CMD_EDGE, timer_now);
      send_word(CMD_CHECK, timer_now - 32'd1000);
      send_edge_after(32'd2_000_000);
      send_word(CMD_EDGE, timer_now - 32'd100);
      send_word(CMD_CHECK, 32'h0);
   endtask

   task automatic test_special_cases();
      configure(32'd1000, 8'd2, 8'd5, 40'hFF_FFFF_FFFF, 4'd15);
      timer_now = 32'h0;
      send_word(CMD_EDGE, timer_now);
      send_edge_after(32'h0020_0000);
      send_edge_after(32'd0);
      send_edge_after(32'd0);
      send_edge_after(32'd10);
      send_edge_after(32'd10);
      send_word(CMD_CHECK, timer_now - 32'd500);
      send_word(CMD_EDGE, timer_now - 32'd3);
      // sum saturation
      configure(32'hFFFF_FFFF, 8'd3, 8'd5, RPM_SCALE_RST, 4'd15);
      repeat (3) send_edge_after(32'hC000_0000);
      // zero counts and ratio act as one
      configure(32'hFFFF_FFFF, 8'd0, 8'd0, RPM_SCALE_RST, 4'd0);
      repeat (2) send_edge_after(32'h8000_0000);
   endtask

   task automatic test_register_lowering();
      configure(32'd100000, HALL_PPR_RST, GEAR_PPR_RST, RPM_SCALE_RST, GEAR_RATIO_RST);
      send_edge_after(32'h8000_0000);
      repeat (4) send_edge_after(32'd2000);
      configure(32'd100000, 8'd3, 8'd3, RPM_SCALE_RST, GEAR_RATIO_RST);
      send_edge_after(32'd2000);
   endtask

   task automatic test_backpressure();
      configure(32'd200000, 8'd4, 8'd9, RPM_SCALE_RST, 4'd3);
      hold_requests++;
      run_random_phase(24, 32'd8000);
   endtask

   task automatic test_random();
      logic [STALL_W-1:0] stall;
      configure(32'd200000, HALL_PPR_RST, GEAR_PPR_RST, RPM_SCALE_RST, GEAR_RATIO_RST);
      run_random_phase(290, 32'd5000);
      configure(32'hFFFF_FFFF, 8'd255, 8'd255, 40'hFF_FFFF_FFFF, 4'd15);
      run_random_phase(290, 32'h1000_0000);
      configure(32'd1, 8'd1, 8'd1, 40'd1, 4'd1);
      run_random_phase(290, 32'd1);
      configure(32'd50000, 8'd3, 8'd7, {$urandom, $urandom}, $urandom_range(1, 15));
      run_random_phase(290, 32'd3000);
      repeat (2) begin
         stall = $urandom_range(1000, 2_000_000);
         configure(stall, $urandom_range(1, 24), $urandom_range(1, 255),
                   {$urandom, $urandom}, $urandom_range(0, 15));
         run_random_phase(145, stall / 4);
      end
   endtask

   initial begin
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_chan.valid = 1'b0;
      req_chan.command = CMD_EDGE;
      req_chan.timestamp = '0;
      rsp_chan.ready = 1'b0;
      tach_cfg.stall_limit = STALL_LIMIT_RST;
      tach_cfg.hall_pulses_per_rev = HALL_PPR_RST;
      tach_cfg.gear_pulses_per_rev = GEAR_PPR_RST;
      tach_cfg.rpm_scale = RPM_SCALE_RST;
      tach_cfg.gear_ratio = GEAR_RATIO_RST;
      last_edge_time = '0;
      is_primed = 1'b0;
      last_period = NO_PERIOD;
      last_period_valid = 1'b0;
      running_sum = '0;
      hall_count = '0;
      gear_index = '0;
      motor_rpm_q = '0;
      gear_rpm_q = '0;
      angle_q = '0;
      rev_period_q = '0;
      timer_now = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_special_cases();
      test_register_lowering();
      test_backpressure();
      test_random();

      wait_idle();
      if (mismatches == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
